>>> rtl/olid_pkg.sv
// Shared definitions for the ordered byte list: field widths, operation and
// status codes, controller state type and the controller/datapath structs.
// No dependencies.
package olid_pkg;

    // Fixed field widths of the request and response
    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int ELEM_W = 8;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // Operation codes (code 3 is a no-op)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_COMMIT
    } olid_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // latch the incoming request
        logic read_issue;   // read the entry addressed by the request
        logic shift_start;  // load the move engine
        logic shift_step;   // move engine runs
        logic commit;       // apply the operation and load the response
    } olid_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic chk_read;     // latched request is a valid read
        logic chk_shift;    // latched request is a valid insert or delete
        logic shift_busy;   // moves still outstanding
        logic out_free;     // response register can take a new response
    } olid_stat_t;

endpackage

>>> rtl/olid_if.sv
// Request and response channel interfaces of the ordered byte list.
// Depends on olid_pkg for the field widths.
interface olid_req_if;
    logic                          valid;
    logic                          ready;
    logic [olid_pkg::OP_W-1:0]     op;
    logic [olid_pkg::POS_W-1:0]    position;
    logic [olid_pkg::ELEM_W-1:0]   element;

    modport source (output valid, op, position, element, input ready);
    modport sink   (input valid, op, position, element, output ready);
endinterface

interface olid_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [olid_pkg::STAT_W-1:0]   status;
    logic [olid_pkg::ELEM_W-1:0]   read_value;
    logic [olid_pkg::CNT_W-1:0]    entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

>>> rtl/olid_ctrl.sv
// Controller state machine of the ordered byte list: sequences check, entry
// moves and commit of one request. Depends on olid_pkg.
module olid_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  olid_pkg::olid_stat_t stat,
    output olid_pkg::olid_cmd_t  cmd
);

    olid_pkg::olid_state_t state_reg;
    olid_pkg::olid_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olid_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olid_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = olid_pkg::S_CHECK;
                end
            end
            olid_pkg::S_CHECK:
            begin
                if (stat.chk_shift)
                begin
                    state_next = olid_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = olid_pkg::S_COMMIT;
                end
            end
            olid_pkg::S_SHIFT:
            begin
                if (!stat.shift_busy)
                begin
                    state_next = olid_pkg::S_COMMIT;
                end
            end
            olid_pkg::S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = olid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olid_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            olid_pkg::S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            olid_pkg::S_CHECK:
            begin
                cmd.read_issue  = stat.chk_read;
                cmd.shift_start = stat.chk_shift;
            end
            olid_pkg::S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
            end
            olid_pkg::S_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/olid_dp.sv
// Datapath of the ordered byte list: entry memory, count, request and
// response registers and the entry move engine. Depends on olid_pkg.
module olid_dp
#(
    parameter int CAPACITY = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [olid_pkg::OP_W-1:0]   op,
    input  logic [olid_pkg::POS_W-1:0]  position,
    input  logic [olid_pkg::ELEM_W-1:0] element,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    output logic [olid_pkg::STAT_W-1:0] rsp_status,
    output logic [olid_pkg::ELEM_W-1:0] rsp_read_value,
    output logic [olid_pkg::CNT_W-1:0]  rsp_entry_count,
    input  olid_pkg::olid_cmd_t         cmd,
    output olid_pkg::olid_stat_t        stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W) + 1;
    localparam int OW = olid_pkg::CNT_W;
    localparam int EW = olid_pkg::ELEM_W;

    // Entry store, one write and one read port
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rdata_reg;

    // Latched request
    logic [olid_pkg::OP_W-1:0]  op_reg;
    logic [olid_pkg::POS_W-1:0] pos_reg;
    logic [EW-1:0]              elem_reg;

    // Count and move engine
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          mv_valid_reg, mv_valid_next;
    logic [AW-1:0] mv_dst_reg, mv_dst_next;

    // Response register
    logic                        out_valid_reg, out_valid_next;
    logic [olid_pkg::STAT_W-1:0] out_status_reg;
    logic [EW-1:0]               out_read_reg;
    logic [OW-1:0]               out_count_reg;

    logic [XW-1:0]               pos_x, cnt_x;
    logic                        is_full, ins_bad, sel_bad;
    logic [olid_pkg::STAT_W-1:0] status;
    logic                        ok_ins, ok_del, ok_read;
    logic [AW-1:0]               pos_idx;
    logic [CW-1:0]               moves;
    logic                        step_go;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        commit_wr;

    // Range and capacity checks on the latched request
    always_comb
    begin
        pos_x   = XW'(pos_reg);
        cnt_x   = XW'(count_reg);
        is_full = (count_reg == CW'(CAPACITY));
        ins_bad = (pos_reg == '0) || (pos_x > (cnt_x + XW'(1)));
        sel_bad = (pos_reg == '0) || (pos_x > cnt_x);
        case (op_reg)
            olid_pkg::OP_INSERT:
            begin
                status = is_full ? olid_pkg::ST_FULL
                       : (ins_bad ? olid_pkg::ST_RANGE : olid_pkg::ST_DONE);
            end
            olid_pkg::OP_DELETE,
            olid_pkg::OP_READ:
            begin
                status = sel_bad ? olid_pkg::ST_RANGE : olid_pkg::ST_DONE;
            end
            default:
            begin
                status = olid_pkg::ST_DONE;
            end
        endcase
        ok_ins  = (op_reg == olid_pkg::OP_INSERT) && (status == olid_pkg::ST_DONE);
        ok_del  = (op_reg == olid_pkg::OP_DELETE) && (status == olid_pkg::ST_DONE);
        ok_read = (op_reg == olid_pkg::OP_READ) && (status == olid_pkg::ST_DONE);
        pos_idx = AW'(pos_reg - olid_pkg::POS_W'(1));
        // insert moves count-pos+1 entries up, delete count-pos entries down
        moves   = ok_ins ? CW'(cnt_x - pos_x + XW'(1)) : CW'(cnt_x - pos_x);
    end

    // Move engine: read one source per cycle, write it one place on next cycle
    always_comb
    begin
        rem_next      = rem_reg;
        ptr_next      = ptr_reg;
        mv_valid_next = 1'b0;
        mv_dst_next   = mv_dst_reg;
        step_go       = cmd.shift_step && (rem_reg != '0);
        if (cmd.shift_start)
        begin
            rem_next = moves;
            ptr_next = ok_ins ? AW'(count_reg - CW'(1)) : AW'(pos_reg);
        end
        else if (step_go)
        begin
            rem_next      = rem_reg - CW'(1);
            ptr_next      = ok_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
            mv_valid_next = 1'b1;
            mv_dst_next   = ok_ins ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
        end
        rd_en   = cmd.read_issue || step_go;
        rd_addr = cmd.read_issue ? pos_idx : ptr_reg;
    end

    // Count update and response handshake
    always_comb
    begin
        commit_wr  = cmd.commit && ok_ins;
        count_next = count_reg;
        if (cmd.commit && ok_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.commit && ok_del)
        begin
            count_next = count_reg - CW'(1);
        end
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rem_reg       <= '0;
            ptr_reg       <= '0;
            mv_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            ptr_reg       <= ptr_next;
            mv_valid_reg  <= mv_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mv_dst_reg <= mv_dst_next;
        if (cmd.accept)
        begin
            op_reg   <= op;
            pos_reg  <= position;
            elem_reg <= element;
        end
        if (cmd.commit)
        begin
            out_status_reg <= status;
            out_read_reg   <= ok_read ? rdata_reg : '0;
            out_count_reg  <= OW'(count_next);
        end
    end

    // Entry memory ports
    always_ff @(posedge clk)
    begin
        if (mv_valid_reg)
        begin
            mem[mv_dst_reg] <= rdata_reg;
        end
        else if (commit_wr)
        begin
            mem[pos_idx] <= elem_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign stat.chk_read   = ok_read;
    assign stat.chk_shift  = ok_ins || ok_del;
    assign stat.shift_busy = (rem_reg != '0) || mv_valid_reg;
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_read_value  = out_read_reg;
    assign rsp_entry_count = out_count_reg;

`ifndef NO_ASSERTIONS
    // A move write and the insert placement never share the write port
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(mv_valid_reg && commit_wr))
        else $error("move write collides with insert write");

    // The count stays within the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A response is only loaded when the register is free
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("response overwritten");

    // A failed operation never reports a read value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != olid_pkg::ST_DONE)) |-> (out_read_reg == '0))
        else $error("read value on failed request");

    // Each issued move lands as a write on the next cycle
    a_move_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_step && (rem_reg != '0) && !cmd.shift_start) |=> mv_valid_reg)
        else $error("move read without write");
`endif

endmodule

>>> rtl/ordered_list_insert_delete.sv
// Ordered byte list of up to CAPACITY entries with insert, delete and read by
// one-based position. A request is taken while the block is idle; a read, a
// refused request or a no-op goes through check and commit, while an insert
// at position p first moves count - p + 1 entries up and a delete at p moves
// count - p entries down. The entry memory moves one entry per cycle through
// its single read and single write port. The list is empty after reset; no
// clearing pass is run. Depends on olid_pkg, olid_if, olid_ctrl and olid_dp.
module ordered_list_insert_delete
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    olid_req_if.sink          req,
    olid_rsp_if.source        rsp
);

    olid_pkg::olid_cmd_t  cmd;
    olid_pkg::olid_stat_t stat;

    // Sequencer
    olid_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    olid_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (req.op),
        .position        (req.position),
        .element         (req.element),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_read_value  (rsp.read_value),
        .rsp_entry_count (rsp.entry_count),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
